// File: rtl/core/tzs_pkg.sv
// Shared types, constants and calendar helpers for the time-zone date and time shift block.
package tzs_pkg;

	localparam int unsigned MinPerDay  = 1440;
	localparam int unsigned MinPerHour = 60;

	// Reciprocal constants for division by a constant.
	// year / 25 == (year * DIV25_MAGIC) >> DIV25_SHIFT for any 16-bit year
	localparam logic [16:0] DIV25_MAGIC = 17'd83887;
	localparam int unsigned DIV25_SHIFT = 21;
	// t / 60 == (t * DIV60_MAGIC) >> DIV60_SHIFT for t in 0..1439
	localparam logic [10:0] DIV60_MAGIC = 11'd1093;
	localparam int unsigned DIV60_SHIFT = 16;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// One calendar date with its weekday.
	typedef struct packed {
		logic [2:0]  weekday;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
	} date_t;

	// Day step decided from the shifted minute count.
	typedef struct packed {
		logic fwd;
		logic bwd;
	} step_t;

	// Length of a month; anything outside 1..12 counts 30 days.
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd30;
		endcase
		return len;
	endfunction

endpackage

// File: rtl/core/tzs_date_roll.sv
// Date rollover by one day forward or back: weekday, day, month and year.
module tzs_date_roll (
	input  tzs_pkg::date_t date_in,
	input  tzs_pkg::step_t step,
	input  logic           leap,
	output tzs_pkg::date_t date_out
);

	logic [4:0] len_cur;
	logic [4:0] len_prev;
	logic [3:0] month_dec;
	logic [5:0] day_inc;
	logic [4:0] month_inc;

	assign len_cur   = tzs_pkg::month_days(date_in.month, leap);
	assign month_dec = date_in.month - 4'd1;
	assign len_prev  = tzs_pkg::month_days(month_dec, leap);
	assign day_inc   = {1'b0, date_in.day} + 6'd1;
	assign month_inc = {1'b0, date_in.month} + 5'd1;

	always_comb begin
		date_out = date_in;
		if (step.fwd) begin
			date_out.weekday = (date_in.weekday == 3'd7) ? 3'd1 : date_in.weekday + 3'd1;
			if (day_inc > {1'b0, len_cur}) begin
				date_out.day = 5'd1;
				if (month_inc > {1'b0, tzs_pkg::MONTH_DEC}) begin
					date_out.month = tzs_pkg::MONTH_JAN;
					date_out.year  = date_in.year + 16'd1;
				end else begin
					date_out.month = month_inc[3:0];
				end
			end else begin
				date_out.day = day_inc[4:0];
			end
		end else if (step.bwd) begin
			date_out.weekday = (date_in.weekday <= 3'd1) ? 3'd7 : date_in.weekday - 3'd1;
			if (date_in.day > 5'd1) begin
				date_out.day = date_in.day - 5'd1;
			end else if (date_in.month == tzs_pkg::MONTH_JAN) begin
				// back into December of the previous year
				date_out.month = tzs_pkg::MONTH_DEC;
				date_out.year  = date_in.year - 16'd1;
				date_out.day   = 5'd31;
			end else begin
				// year unchanged, so the leap flag still holds
				date_out.month = month_dec;
				date_out.day   = len_prev;
			end
		end
	end

endmodule

// File: rtl/core/timezone_date_time_shift_top.sv
// Top level of the time-zone date and time shift block: four-stage pipeline and APB register.
//
// Use: write the signed offset in minutes to the offset register (byte address 0)
// through the APB port while the block is idle; reset clears it to zero. Present one
// RTC reading on the *_in ports with start high. busy stays low, so a reading is
// accepted on every cycle in which start is high, one per cycle without gaps.
// The local time and date appear on the *_out ports from the s4 output register, for one
// cycle, marked by done. The receiver takes each result in that cycle and cannot hold it
// off; results leave in the order readings entered.
// Stages:
//   s1  minute count hour*60 + minute + offset; year times the reciprocal of 25
//   s2  leap year from year mod 4, 16 and 25; day step and wrapped minute count
//   s3  day, month, year and weekday rollover; hour from the minute count
//   s4  minute as remainder; output register
// Throughput is one reading per cycle.
// Reset empties the pipeline: no done follows reset until a new transfer.
module timezone_date_time_shift_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// reading in
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  hour_in,
	input  logic [5:0]  minute_in,
	input  logic [5:0]  second_in,
	input  logic [2:0]  weekday_in,
	input  logic [4:0]  day_in,
	input  logic [3:0]  month_in,
	input  logic [15:0] year_in,
	// result out
	output logic        done,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [5:0]  second_out,
	output logic [2:0]  weekday_out,
	output logic [4:0]  day_out,
	output logic [3:0]  month_out,
	output logic [15:0] year_out
);

	// ---------------------------------------------------------------- register
	logic [11:0] offset_q;
	logic        reg_sel;

	assign pready  = 1'b1;
	// paddr[2] is the word address; the low bits are ignored
	assign reg_sel = (paddr[2] == 1'b0);
	assign prdata  = reg_sel ? {20'd0, offset_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 12'd0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			offset_q <= pwdata[11:0];
		end
	end

	// The pipeline never stalls, so every start is a transfer.
	assign busy = 1'b0;

	// ---------------------------------------------------------------- stage 1
	logic        accept;
	logic [10:0] hm;
	logic signed [12:0] total;
	logic [32:0] year_prod;

	logic              vld_s1;
	logic signed [12:0] total_s1;
	logic [11:0]       q25_s1;
	logic [5:0]        second_s1;
	tzs_pkg::date_t    date_s1;

	assign accept    = start && !busy;
	assign hm        = 11'(hour_in * 11'd60) + {5'd0, minute_in};
	assign total     = $signed({2'b00, hm}) + 13'($signed(offset_q));
	assign year_prod = {17'd0, year_in} * {16'd0, tzs_pkg::DIV25_MAGIC};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			total_s1     <= total;
			q25_s1       <= year_prod[32:tzs_pkg::DIV25_SHIFT];
			second_s1    <= second_in;
			date_s1.weekday <= weekday_in;
			date_s1.day  <= day_in;
			date_s1.month <= month_in;
			date_s1.year <= year_in;
		end
	end

	// ---------------------------------------------------------------- stage 2
	logic [15:0]        prod25;
	logic               div25;
	logic               leap;
	tzs_pkg::step_t     step;
	logic signed [12:0] adj;
	logic [10:0]        t_sat;

	logic           vld_s2;
	tzs_pkg::step_t step_s2;
	logic           leap_s2;
	logic [10:0]    t_s2;
	logic [5:0]     second_s2;
	tzs_pkg::date_t date_s2;

	assign prod25 = {4'd0, q25_s1} * 16'd25;
	assign div25  = (prod25 == date_s1.year);
	// divisible by 4, and not by 100 unless by 400 (400 = 16 * 25)
	assign leap   = (date_s1.year[1:0] == 2'd0) && (!div25 || (date_s1.year[3:0] == 4'd0));

	always_comb begin
		step.fwd = (total_s1 >= 13'sd1440);
		step.bwd = (total_s1 < 13'sd0);
		if (step.fwd) begin
			adj = total_s1 - 13'sd1440;
		end else if (step.bwd) begin
			adj = total_s1 + 13'sd1440;
		end else begin
			adj = total_s1;
		end
		// clamp what a single day step cannot bring back into the day
		if (adj < 13'sd0) begin
			t_sat = 11'd0;
		end else if (adj > 13'sd1439) begin
			t_sat = 11'd1439;
		end else begin
			t_sat = adj[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			step_s2   <= step;
			leap_s2   <= leap;
			t_s2      <= t_sat;
			second_s2 <= second_s1;
			date_s2   <= date_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	tzs_pkg::date_t date_roll;
	logic [21:0]    hour_prod;

	logic           vld_s3;
	logic [4:0]     hour_s3;
	logic [10:0]    t_s3;
	logic [5:0]     second_s3;
	tzs_pkg::date_t date_s3;

	tzs_date_roll u_date_roll (
		.date_in  (date_s2),
		.step     (step_s2),
		.leap     (leap_s2),
		.date_out (date_roll)
	);

	assign hour_prod = {11'd0, t_s2} * {11'd0, tzs_pkg::DIV60_MAGIC};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			hour_s3   <= hour_prod[tzs_pkg::DIV60_SHIFT +: 5];
			t_s3      <= t_s2;
			second_s3 <= second_s2;
			date_s3   <= date_roll;
		end
	end

	// ---------------------------------------------------------------- stage 4
	logic [10:0]    minute_rem;
	logic           vld_s4;
	logic [4:0]     hour_s4;
	logic [5:0]     minute_s4;
	logic [5:0]     second_s4;
	tzs_pkg::date_t date_s4;

	assign minute_rem = t_s3 - 11'(hour_s3 * 11'd60);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			hour_s4   <= hour_s3;
			minute_s4 <= minute_rem[5:0];
			second_s4 <= second_s3;
			date_s4   <= date_s3;
		end
	end

	// Drive the result for the single cycle that done marks.
	assign done        = vld_s4;
	assign hour_out    = hour_s4;
	assign minute_out  = minute_s4;
	assign second_out  = second_s4;
	assign weekday_out = date_s4.weekday;
	assign day_out     = date_s4.day;
	assign month_out   = date_s4.month;
	assign year_out    = date_s4.year;

endmodule
